FILE: rtl/altr_pkg.sv
package altr_pkg;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_FWD   = 3'd2;
  localparam logic [2:0] CMD_BWD   = 3'd3;
  localparam logic [2:0] CMD_LEARN = 3'd4;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_OUTPUT = 2'd1;
  localparam logic [1:0] KIND_IGRAD  = 2'd2;

  localparam logic [1:0] REG_IN_USED    = 2'd0;
  localparam logic [1:0] REG_OUT_USED   = 2'd1;
  localparam logic [1:0] REG_LEARN_RATE = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [8:0]         position;
    logic signed [15:0] operand_value;
    logic               last_element;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [8:0]         result_index;
    logic signed [15:0] result_value;
    logic               last_result;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLR, OP_WWR, OP_WRD, OP_WRD0, OP_XST, OP_FMAC, OP_FBIAS,
    OP_FEMIT, OP_BMAC, OP_BBIAS, OP_GEMIT, OP_LEARN
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               first;
    logic               last;
    logic [8:0]         rindex;
    logic signed [15:0] val;
  } dp_cmd_t;

  function automatic logic is_emit(op_t op);
    return (op == OP_WRD) || (op == OP_WRD0) || (op == OP_FEMIT) || (op == OP_GEMIT);
  endfunction

endpackage

FILE: rtl/altr_dp.sv
module altr_dp #(
  parameter int MAX_IN = 16,
  parameter int MAX_OUT = 16,
  parameter int AW = 9,
  parameter int XW = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  altr_pkg::dp_cmd_t cmd,
  input  logic [AW-1:0]     addr,
  input  logic [XW-1:0]     xidx,
  input  logic [15:0]       learn_rate,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output altr_pkg::out_word_t out_word
);
  import altr_pkg::*;

  localparam int WDEPTH = (MAX_IN + 1) * MAX_OUT;
  localparam int ACCW = 32 + $clog2(MAX_IN + 1);

  logic signed [15:0] wmem [WDEPTH];
  logic signed [31:0] gmem [WDEPTH];
  logic signed [15:0] xmem [MAX_IN];
  logic signed [39:0] iacc_r [MAX_IN];

  dp_cmd_t            a_cmd_r, b_cmd_r;
  logic [AW-1:0]      a_addr_r, b_addr_r;
  logic [XW-1:0]      a_xidx_r, b_xidx_r;
  logic signed [15:0] a_w_r, a_x_r, b_w_r;
  logic signed [31:0] a_g_r, b_g_r;
  logic signed [31:0] p1_r, p2_r;
  logic signed [48:0] p3_r;
  logic signed [31:0] p1_nxt, p2_nxt;
  logic signed [48:0] p3_nxt;
  logic signed [ACCW-1:0] acc_r;
  out_word_t          out_r;
  logic               out_v_r;

  logic               w_we, g_we;
  logic signed [15:0] w_wd;
  logic signed [31:0] g_wd;
  logic signed [32:0] gsum;
  logic signed [40:0] isum;
  logic signed [ACCW:0] fsum;
  logic signed [49:0] lsum;
  logic signed [32:0] fres, ires, lres;

  function automatic logic signed [15:0] sat16(logic signed [32:0] v);
    if (v > 33'sd32767) return 16'sh7fff;
    if (v < -33'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [32:0] v);
    if (v[32] != v[31]) return v[32] ? 32'sh80000000 : 32'sh7fffffff;
    return v[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(logic signed [40:0] v);
    if (v[40] != v[39]) return v[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    return v[39:0];
  endfunction

  always_comb begin
    p1_nxt = '0;
    p2_nxt = '0;
    p3_nxt = '0;
    case (a_cmd_r.op)
      OP_FMAC:  p1_nxt = a_w_r * a_x_r;
      OP_FBIAS: p1_nxt = {{8{a_w_r[15]}}, a_w_r, 8'h00};
      OP_BMAC: begin
        p1_nxt = a_cmd_r.val * a_w_r;
        p2_nxt = a_x_r * a_cmd_r.val;
      end
      OP_BBIAS: p2_nxt = {{8{a_cmd_r.val[15]}}, a_cmd_r.val, 8'h00};
      OP_LEARN: p3_nxt = $signed({1'b0, learn_rate}) * a_g_r;
      default: ;
    endcase
  end

  always_comb begin
    gsum = {b_g_r[31], b_g_r} + {p2_r[31], p2_r};
    isum = {iacc_r[b_xidx_r][39], iacc_r[b_xidx_r]} + 41'(p1_r);
    fsum = {acc_r[ACCW-1], acc_r} + (ACCW+1)'(128);
    fres = 33'($signed(fsum[ACCW:8]));
    lsum = {p3_r[48], p3_r} + 50'sd8388608;
    lres = 33'(b_w_r) - 33'($signed(lsum[49:24]));
    ires = 33'({iacc_r[b_xidx_r][39], iacc_r[b_xidx_r]} + 41'sd128 >>> 8);
    w_we = 1'b0;
    g_we = 1'b0;
    w_wd = '0;
    g_wd = '0;
    case (b_cmd_r.op)
      OP_CLR: begin
        w_we = 1'b1;
        g_we = 1'b1;
      end
      OP_WWR: begin
        w_we = 1'b1;
        w_wd = b_cmd_r.val;
      end
      OP_BMAC, OP_BBIAS: begin
        g_we = 1'b1;
        g_wd = sat32(gsum);
      end
      OP_LEARN: begin
        w_we = 1'b1;
        w_wd = sat16(lres);
        g_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    a_w_r <= wmem[addr];
    a_g_r <= gmem[addr];
    a_x_r <= xmem[xidx];
    if (cmd.op == OP_XST) begin
      xmem[xidx] <= cmd.val;
    end
    if (w_we) begin
      wmem[b_addr_r] <= w_wd;
    end
    if (g_we) begin
      gmem[b_addr_r] <= g_wd;
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r <= addr;
    a_xidx_r <= xidx;
    b_addr_r <= a_addr_r;
    b_xidx_r <= a_xidx_r;
    b_w_r    <= a_w_r;
    b_g_r    <= a_g_r;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    p3_r     <= p3_nxt;
    if (b_cmd_r.op == OP_FMAC || b_cmd_r.op == OP_FBIAS) begin
      acc_r <= b_cmd_r.first ? ACCW'(p1_r) : acc_r + ACCW'(p1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cmd_r <= '0;
      b_cmd_r <= '0;
      out_v_r <= 1'b0;
      for (int k = 0; k < MAX_IN; k++) begin
        iacc_r[k] <= '0;
      end
    end else begin
      a_cmd_r <= cmd;
      b_cmd_r <= a_cmd_r;
      if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
      case (b_cmd_r.op)
        OP_BMAC: iacc_r[b_xidx_r] <= sat40(isum);
        OP_WRD, OP_WRD0: begin
          out_v_r <= 1'b1;
          out_r <= {KIND_WEIGHT, b_cmd_r.rindex,
                    (b_cmd_r.op == OP_WRD) ? b_w_r : 16'sh0000, 1'b1};
        end
        OP_FEMIT: begin
          out_v_r <= 1'b1;
          out_r <= {KIND_OUTPUT, b_cmd_r.rindex, sat16(fres), b_cmd_r.last};
        end
        OP_GEMIT: begin
          out_v_r <= 1'b1;
          out_r <= {KIND_IGRAD, b_cmd_r.rindex, sat16(ires), b_cmd_r.last};
          if (b_cmd_r.last) begin
            for (int k = 0; k < MAX_IN; k++) begin
              iacc_r[k] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign busy      = out_v_r || is_emit(cmd.op) || is_emit(a_cmd_r.op) || is_emit(b_cmd_r.op);
  assign out_valid = out_v_r;
  assign out_word  = out_r;

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    is_emit(b_cmd_r.op) |-> !out_v_r) else $error("result register overwritten");
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({is_emit(cmd.op), is_emit(a_cmd_r.op), is_emit(b_cmd_r.op)}) <= 1)
    else $error("more than one result in flight");
  a_iacc_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (b_cmd_r.op == OP_GEMIT && b_cmd_r.last) |=> iacc_r[0] == '0)
    else $error("input gradients not cleared");
`endif

endmodule

FILE: rtl/altr_ctrl.sv
module altr_ctrl #(
  parameter int MAX_IN = 16,
  parameter int MAX_OUT = 16,
  parameter int AW = 9,
  parameter int XW = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  altr_pkg::in_word_t in_word,
  input  logic [4:0]         in_used,
  input  logic [4:0]         out_used,
  input  logic               dp_busy,
  output altr_pkg::dp_cmd_t  cmd,
  output logic [AW-1:0]      addr,
  output logic [XW-1:0]      xidx
);
  import altr_pkg::*;

  localparam int WDEPTH = (MAX_IN + 1) * MAX_OUT;
  localparam int NIW = $clog2(MAX_IN + 1);
  localparam int NOW = $clog2(MAX_OUT + 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_FWD, ST_FEMIT, ST_BBASE, ST_BWD, ST_GEMIT,
    ST_LEARN, ST_DRAIN
  } state_t;

  state_t        state_r;
  in_word_t      item_r;
  dp_cmd_t       cmd_r;
  logic [AW-1:0] addr_r, adr_r;
  logic [XW-1:0] xidx_r;
  logic [NIW-1:0] i_r, ni;
  logic [NOW-1:0] j_r, no;
  logic [1:0]    drain_r;
  logic [AW+9:0] bprod;
  logic          accept;

  always_comb begin
    if (in_used == 5'd0) ni = NIW'(1);
    else if (32'(in_used) > MAX_IN) ni = NIW'(MAX_IN);
    else ni = NIW'(in_used);
    if (out_used == 5'd0) no = NOW'(1);
    else if (32'(out_used) > MAX_OUT) no = NOW'(MAX_OUT);
    else no = NOW'(out_used);
    bprod = (AW+10)'(item_r.position) * (AW+10)'(ni + 1'b1);
  end

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cmd_r   <= '0;
      adr_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      drain_r <= '0;
    end else begin
      cmd_r.op    <= OP_NOP;
      cmd_r.first <= 1'b0;
      cmd_r.last  <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          cmd_r.op <= OP_CLR;
          addr_r   <= adr_r;
          adr_r    <= adr_r + 1'b1;
          if (32'(adr_r) == WDEPTH - 1) begin
            state_r <= ST_DRAIN;
            drain_r <= 2'd3;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item_r  <= in_word;
            cmd_r.val <= in_word.operand_value;
            adr_r   <= '0;
            i_r     <= '0;
            j_r     <= '0;
            drain_r <= 2'd3;
            state_r <= ST_DRAIN;
            unique case (in_word.cmd)
              CMD_WRITE: begin
                if (32'(in_word.position) < WDEPTH) cmd_r.op <= OP_WWR;
                addr_r <= AW'(in_word.position);
              end
              CMD_READ: state_r <= ST_RD;
              CMD_FWD: begin
                if (10'(in_word.position) < 10'(ni)) cmd_r.op <= OP_XST;
                xidx_r <= XW'(in_word.position);
                if (in_word.last_element) state_r <= ST_FWD;
              end
              CMD_BWD: begin
                if (10'(in_word.position) < 10'(no)) state_r <= ST_BBASE;
                else if (in_word.last_element) state_r <= ST_GEMIT;
              end
              CMD_LEARN: state_r <= ST_LEARN;
              default: ;
            endcase
          end
        end
        ST_RD: begin
          if (!dp_busy) begin
            cmd_r.op     <= (32'(item_r.position) < WDEPTH) ? OP_WRD : OP_WRD0;
            cmd_r.rindex <= item_r.position;
            addr_r       <= AW'(item_r.position);
            state_r      <= ST_DRAIN;
          end
        end
        ST_FWD: begin
          addr_r <= adr_r;
          adr_r  <= adr_r + 1'b1;
          xidx_r <= XW'(i_r);
          if (i_r < ni) begin
            cmd_r.op    <= OP_FMAC;
            cmd_r.first <= (i_r == '0);
            i_r         <= i_r + 1'b1;
          end else begin
            cmd_r.op <= OP_FBIAS;
            state_r  <= ST_FEMIT;
          end
        end
        ST_FEMIT: begin
          if (!dp_busy) begin
            cmd_r.op     <= OP_FEMIT;
            cmd_r.rindex <= 9'(j_r);
            cmd_r.last   <= (j_r == no - 1'b1);
            i_r          <= '0;
            j_r          <= j_r + 1'b1;
            state_r      <= (j_r == no - 1'b1) ? ST_DRAIN : ST_FWD;
          end
        end
        ST_BBASE: begin
          adr_r   <= bprod[AW-1:0];
          state_r <= ST_BWD;
        end
        ST_BWD: begin
          addr_r <= adr_r;
          adr_r  <= adr_r + 1'b1;
          xidx_r <= XW'(i_r);
          if (i_r < ni) begin
            cmd_r.op <= OP_BMAC;
            i_r      <= i_r + 1'b1;
          end else begin
            cmd_r.op <= OP_BBIAS;
            i_r      <= '0;
            state_r  <= item_r.last_element ? ST_GEMIT : ST_DRAIN;
          end
        end
        ST_GEMIT: begin
          if (!dp_busy) begin
            cmd_r.op     <= OP_GEMIT;
            cmd_r.rindex <= 9'(i_r);
            cmd_r.last   <= (i_r == ni - 1'b1);
            xidx_r       <= XW'(i_r);
            i_r          <= i_r + 1'b1;
            if (i_r == ni - 1'b1) state_r <= ST_DRAIN;
          end
        end
        ST_LEARN: begin
          cmd_r.op <= OP_LEARN;
          addr_r   <= adr_r;
          adr_r    <= adr_r + 1'b1;
          if (32'(adr_r) == WDEPTH - 1) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          drain_r <= drain_r - 1'b1;
          if (drain_r == 2'd0) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign cmd  = cmd_r;
  assign addr = addr_r;
  assign xidx = xidx_r;

`ifndef SYNTH
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> cmd_r.op == OP_NOP) else $error("operation issued while idle");
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    is_emit(cmd_r.op) |-> $past(!dp_busy)) else $error("result issued while busy");
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE) else $error("word accepted without work");
`endif

endmodule

FILE: rtl/affine_layer_train_engine.sv
// Channel | Direction | Handshake             | Word
// in_     | input     | in_valid / in_stall   | in_word  (cmd, position, operand_value, last)
// out_    | output    | out_valid / out_stall | out_word (kind, index, value, last)
// cfg_    | input     | APB write / read      | in_used, out_used, learn_rate
// After reset a clearing pass zeroes every entry of the weight and gradient memories,
// and no word is accepted until it ends.
// The last forward element starts the forward pass over all used outputs on the single MAC.
// A backward element updates the gradients of its output; the last one also emits the input gradients.
// Learn updates every memory entry, one entry per cycle; out_stall holds results.
module affine_layer_train_engine #(
  parameter int MAX_IN = 16,
  parameter int MAX_OUT = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  altr_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output altr_pkg::out_word_t out_word,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import altr_pkg::*;

  localparam int WDEPTH = (MAX_IN + 1) * MAX_OUT;
  localparam int AW = $clog2(WDEPTH);
  localparam int XW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;

  logic [4:0]    in_used_r, out_used_r;
  logic [15:0]   learn_rate_r;
  dp_cmd_t       cmd;
  logic [AW-1:0] addr;
  logic [XW-1:0] xidx;
  logic          dp_busy;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_used_r    <= 5'd16;
      out_used_r   <= 5'd16;
      learn_rate_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        REG_IN_USED:    in_used_r    <= cfg_pwdata[4:0];
        REG_OUT_USED:   out_used_r   <= cfg_pwdata[4:0];
        REG_LEARN_RATE: learn_rate_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_IN_USED:    cfg_prdata = {27'd0, in_used_r};
      REG_OUT_USED:   cfg_prdata = {27'd0, out_used_r};
      REG_LEARN_RATE: cfg_prdata = {16'd0, learn_rate_r};
      default:        cfg_prdata = '0;
    endcase
  end

  altr_ctrl #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT), .AW(AW), .XW(XW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .in_used  (in_used_r),
    .out_used (out_used_r),
    .dp_busy  (dp_busy),
    .cmd      (cmd),
    .addr     (addr),
    .xidx     (xidx)
  );

  altr_dp #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT), .AW(AW), .XW(XW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .addr       (addr),
    .xidx       (xidx),
    .learn_rate (learn_rate_r),
    .busy       (dp_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule
